### rtl/srzab_pkg.sv
// Shared constants, types and register codes of the sprite rotate, zoom and blend block.
`default_nettype none
package srzab_pkg;

	localparam int TEX_WIDTH   = 256;
	localparam int TEX_HEIGHT  = 256;
	localparam int COORD_LIMIT = 32768;
	localparam int TEX_WORDS   = TEX_WIDTH * TEX_HEIGHT;
	localparam int TEX_AW      = $clog2(TEX_WORDS);
	localparam int Q12         = 12;

	localparam int CFG_IW = 3;
	localparam int CFG_DW = 22;
	localparam int IN_DW  = 112;
	localparam int IN_UW  = 3;
	localparam int OUT_DW = 32;
	localparam int OUT_UW = 1;

	localparam logic signed [16:0] COORD_LO = 17'(-COORD_LIMIT);
	localparam logic signed [16:0] COORD_HI = 17'(COORD_LIMIT - 1);

	localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
	localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_RENDER = 1'b1
	} op_t;

	typedef enum logic [CFG_IW-1:0] {
		REG_SIN     = 3'd0,
		REG_COS     = 3'd1,
		REG_SCALE_X = 3'd2,
		REG_SCALE_Y = 3'd3,
		REG_LEFT    = 3'd4,
		REG_TOP     = 3'd5,
		REG_RIGHT   = 3'd6,
		REG_BOTTOM  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [13:0] sin_q12;
		logic signed [13:0] cos_q12;
		logic signed [21:0] scale_x_inv_q12;
		logic signed [21:0] scale_y_inv_q12;
		logic signed [15:0] src_left;
		logic signed [15:0] src_top;
		logic signed [15:0] src_right;
		logic signed [15:0] src_bottom;
	} cfg_t;

	typedef struct packed {
		op_t                op;
		logic [7:0]         tex_col;
		logic [7:0]         tex_row;
		logic [31:0]        texel;
		logic signed [15:0] dst_x;
		logic signed [15:0] dst_y;
		logic [31:0]        dst_pixel;
		logic               dst_no_alpha;
		logic               src_no_alpha;
	} in_t;

	// Fields that ride along the transform stages untouched.
	typedef struct packed {
		op_t               op;
		logic [31:0]       pix;
		logic              dna;
		logic              sna;
		logic              ld_ok;
		logic [TEX_AW-1:0] ld_addr;
	} carry_t;

	typedef struct packed {
		carry_t             cr;
		logic               bad;
		logic signed [29:0] nx;
		logic signed [29:0] ny;
	} xf_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] pix;
		logic        dna;
		logic        sna;
		logic        hit;
	} fe_t;

endpackage
`default_nettype wire

### rtl/srzab_ram.sv
// Generic simple dual-port RAM with a registered read.
`default_nettype none
module srzab_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/srzab_xform.sv
// Four pipeline stages that rotate and scale a destination coordinate into source space.
`default_nettype none
module srzab_xform (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire srzab_pkg::cfg_t  cfg,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire srzab_pkg::in_t   in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output srzab_pkg::xf_t        out_data
);
	import srzab_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	carry_t cr_c, cr_s1, cr_s2, cr_s3, cr_s4;
	logic   bad_c, bad_s1, bad_s2, bad_s3, bad_s4;

	logic signed [16:0] x17, y17;
	logic signed [29:0] pxc_s1, pys_s1, pxs_s1, pyc_s1;
	logic signed [18:0] r_s2, q_s2;
	logic signed [40:0] prx_s3, pqy_s3;
	logic signed [29:0] nx_s4, ny_s4;

	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_comb begin
		x17 = 17'(in_data.dst_x);
		y17 = 17'(in_data.dst_y);
		bad_c = (x17 < COORD_LO) || (x17 > COORD_HI) || (y17 < COORD_LO) || (y17 > COORD_HI);
		cr_c.op    = in_data.op;
		cr_c.pix   = (in_data.op == OP_RENDER) ? in_data.dst_pixel : in_data.texel;
		cr_c.dna   = in_data.dst_no_alpha;
		cr_c.sna   = in_data.src_no_alpha;
		cr_c.ld_ok = (32'(in_data.tex_col) < TEX_WIDTH) && (32'(in_data.tex_row) < TEX_HEIGHT);
		cr_c.ld_addr = TEX_AW'(TEX_AW'(in_data.tex_row) * TEX_AW'(TEX_WIDTH)
			+ TEX_AW'(in_data.tex_col));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			cr_s1  <= cr_c;
			bad_s1 <= bad_c;
			pxc_s1 <= 30'(in_data.dst_x) * 30'(cfg.cos_q12);
			pys_s1 <= 30'(in_data.dst_y) * 30'(cfg.sin_q12);
			pxs_s1 <= 30'(in_data.dst_x) * 30'(cfg.sin_q12);
			pyc_s1 <= 30'(in_data.dst_y) * 30'(cfg.cos_q12);
		end
		if (en_s2) begin
			cr_s2  <= cr_s1;
			bad_s2 <= bad_s1 || (cfg.scale_x_inv_q12 == '0) || (cfg.scale_y_inv_q12 == '0);
			r_s2   <= 19'((31'(pxc_s1) - 31'(pys_s1)) >>> Q12);
			q_s2   <= 19'((31'(pxs_s1) + 31'(pyc_s1)) >>> Q12);
		end
		if (en_s3) begin
			cr_s3  <= cr_s2;
			bad_s3 <= bad_s2;
			prx_s3 <= 41'(r_s2) * 41'(cfg.scale_x_inv_q12);
			pqy_s3 <= 41'(q_s2) * 41'(cfg.scale_y_inv_q12);
		end
		if (en_s4) begin
			cr_s4  <= cr_s3;
			bad_s4 <= bad_s3;
			// A negative scale steps one texel back so a flip lands on the mirrored texel.
			nx_s4  <= 30'(prx_s3 >>> Q12) - $signed({29'd0, cfg.scale_x_inv_q12[21]});
			ny_s4  <= 30'(pqy_s3 >>> Q12) - $signed({29'd0, cfg.scale_y_inv_q12[21]});
		end
	end

	assign out_valid   = v_s4;
	assign out_data.cr  = cr_s4;
	assign out_data.bad = bad_s4;
	assign out_data.nx  = nx_s4;
	assign out_data.ny  = ny_s4;

endmodule
`default_nettype wire

### rtl/srzab_fetch.sv
// Window test, texel addressing and the texture store with its load and fetch port.
`default_nettype none
module srzab_fetch (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire srzab_pkg::cfg_t cfg,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire srzab_pkg::xf_t  in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output srzab_pkg::fe_t       out_data,
	output logic [31:0]          tex
);
	import srzab_pkg::*;

	logic               v_s5, en_s5;
	fe_t                fe_s5;
	logic signed [30:0] col, row;
	logic               in_win, in_tex, hit;
	logic [TEX_AW-1:0]  rd_addr;
	logic               ram_we, ram_re;

	assign en_s5    = !v_s5 || out_ready;
	assign in_ready = en_s5;

	always_comb begin
		col = 31'(in_data.nx) - 31'(cfg.src_left);
		row = 31'(in_data.ny) - 31'(cfg.src_top);
		in_win = (in_data.nx >= 30'(cfg.src_left)) && (in_data.nx < 30'(cfg.src_right))
			&& (in_data.ny >= 30'(cfg.src_top)) && (in_data.ny < 30'(cfg.src_bottom));
		in_tex = (col < 31'(TEX_WIDTH)) && (row < 31'(TEX_HEIGHT));
		hit = (in_data.cr.op == OP_RENDER) && !in_data.bad && in_win && in_tex;
		rd_addr = TEX_AW'(TEX_AW'(row) * TEX_AW'(TEX_WIDTH) + TEX_AW'(col));
		ram_we = en_s5 && in_valid && (in_data.cr.op == OP_LOAD) && in_data.cr.ld_ok;
		ram_re = en_s5 && in_valid && hit;
	end

	srzab_ram #(
		.WIDTH(32),
		.DEPTH(TEX_WORDS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(in_data.cr.ld_addr),
		.wdata(in_data.cr.pix),
		.re   (ram_re),
		.raddr(rd_addr),
		.rdata(tex)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en_s5) begin
			v_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			fe_s5.op  <= in_data.cr.op;
			fe_s5.pix <= in_data.cr.pix;
			fe_s5.dna <= in_data.cr.dna;
			fe_s5.sna <= in_data.cr.sna;
			fe_s5.hit <= hit;
		end
	end

	assign out_valid = v_s5;
	assign out_data  = fe_s5;

endmodule
`default_nettype wire

### rtl/srzab_blend.sv
// Copy or alpha blend of the fetched texel over the destination pixel, with the output register.
`default_nettype none
module srzab_blend (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire srzab_pkg::fe_t  in_data,
	input  wire logic [31:0]     tex,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [31:0]          out_pixel,
	output logic                 changed
);
	import srzab_pkg::*;

	logic        v_s6, en_s6;
	logic [31:0] pix_s6;
	logic        chg_s6;
	logic [7:0]  sa, da;
	logic [8:0]  a1, a2;
	logic [16:0] mix [3];
	logic [31:0] blended, res;
	logic        res_chg;

	assign en_s6    = !v_s6 || out_ready;
	assign in_ready = en_s6;

	always_comb begin
		sa = tex[31:24] | {8{in_data.sna}};
		da = in_data.pix[31:24] | {8{in_data.dna}};
		a1 = {1'b0, sa} + 9'd1;
		a2 = 9'd256 - {1'b0, sa};
		blended[31:24] = ALPHA_OPAQUE;
		for (int ch = 0; ch < 3; ch++) begin
			mix[ch] = 17'(tex[8*ch +: 8]) * 17'(a1) + 17'(in_data.pix[8*ch +: 8]) * 17'(a2);
			blended[8*ch +: 8] = mix[ch][15:8];
		end
		if (!in_data.hit || (sa == ALPHA_CLEAR)) begin
			res     = in_data.pix;
			res_chg = 1'b0;
		end else if ((da == ALPHA_CLEAR) || (sa == ALPHA_OPAQUE)) begin
			res     = tex;
			res_chg = 1'b1;
		end else begin
			res     = blended;
			res_chg = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en_s6) begin
			v_s6 <= in_valid && (in_data.op == OP_RENDER);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			pix_s6 <= res;
			chg_s6 <= res_chg;
		end
	end

	assign out_valid = v_s6;
	assign out_pixel = pix_s6;
	assign changed   = chg_s6;

endmodule
`default_nettype wire

### rtl/sprite_rotozoom_alpha_blend.sv
// Top level of the sprite rotate, zoom and alpha blend block.
//
//  channel  direction  handshake          contents
//  s_*      in         tvalid/tready      texel load or destination pixel to render
//  m_*      out        tvalid/tready      new destination pixel, one per render transaction
//  cfg_*    in         cfg_we             transform and source window registers
//
// One transaction is accepted per cycle unless a stall at m_* has backed up the stages;
// a render result passes the six register stages: products, rotate, scale products,
// source coordinate, window test with store access, and blend into the output register.
// Each stage advances when the one after it is empty or advancing, so a stall at m_* holds
// everything in place while bubbles ahead of it still fill.
// Reset clears only the valid bits and config registers, not data or the texture store.
`default_nettype none
module sprite_rotozoom_alpha_blend (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// tex_col, tex_row, texel, dst_x, dst_y, dst_pixel
	input  wire logic [srzab_pkg::IN_DW-1:0]      s_tdata,
	// op, dst_no_alpha, src_no_alpha
	input  wire logic [srzab_pkg::IN_UW-1:0]      s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// out_pixel
	output logic [srzab_pkg::OUT_DW-1:0]          m_tdata,
	// changed
	output logic [srzab_pkg::OUT_UW-1:0]          m_tuser,
	input  wire logic                             cfg_we,
	input  wire logic [srzab_pkg::CFG_IW-1:0]     cfg_idx,
	input  wire logic [srzab_pkg::CFG_DW-1:0]     cfg_data
);
	import srzab_pkg::*;

	cfg_t cfg_q;
	in_t  in_data;
	xf_t  xf_data;
	fe_t  fe_data;
	logic xf_valid, xf_ready, fe_valid, fe_ready;
	logic [31:0] tex;
	logic [31:0] out_pixel;
	logic        changed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sin_q12         <= 14'sd0;
			cfg_q.cos_q12         <= 14'sd4096;
			cfg_q.scale_x_inv_q12 <= 22'sd4096;
			cfg_q.scale_y_inv_q12 <= 22'sd4096;
			cfg_q.src_left        <= 16'sd0;
			cfg_q.src_top         <= 16'sd0;
			cfg_q.src_right       <= 16'sd256;
			cfg_q.src_bottom      <= 16'sd256;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_SIN:     cfg_q.sin_q12         <= cfg_data[13:0];
				REG_COS:     cfg_q.cos_q12         <= cfg_data[13:0];
				REG_SCALE_X: cfg_q.scale_x_inv_q12 <= cfg_data[21:0];
				REG_SCALE_Y: cfg_q.scale_y_inv_q12 <= cfg_data[21:0];
				REG_LEFT:    cfg_q.src_left        <= cfg_data[15:0];
				REG_TOP:     cfg_q.src_top         <= cfg_data[15:0];
				REG_RIGHT:   cfg_q.src_right       <= cfg_data[15:0];
				REG_BOTTOM:  cfg_q.src_bottom      <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		in_data.op           = op_t'(s_tuser[0]);
		in_data.dst_no_alpha = s_tuser[1];
		in_data.src_no_alpha = s_tuser[2];
		in_data.tex_col      = s_tdata[7:0];
		in_data.tex_row      = s_tdata[15:8];
		in_data.texel        = s_tdata[47:16];
		in_data.dst_x        = s_tdata[63:48];
		in_data.dst_y        = s_tdata[79:64];
		in_data.dst_pixel    = s_tdata[111:80];
	end

	srzab_xform u_xform (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_data  (in_data),
		.out_valid(xf_valid),
		.out_ready(xf_ready),
		.out_data (xf_data)
	);

	srzab_fetch u_fetch (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (xf_valid),
		.in_ready (xf_ready),
		.in_data  (xf_data),
		.out_valid(fe_valid),
		.out_ready(fe_ready),
		.out_data (fe_data),
		.tex      (tex)
	);

	srzab_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fe_valid),
		.in_ready (fe_ready),
		.in_data  (fe_data),
		.tex      (tex),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_pixel(out_pixel),
		.changed  (changed)
	);

	assign m_tdata = out_pixel;
	assign m_tuser = changed;

endmodule
`default_nettype wire

### rtl/srzab_checker.sv
// Port-level assertions for the sprite rotate, zoom and blend block, bound to its top level.
`default_nettype none
module srzab_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         s_tvalid,
	input wire logic                         s_tready,
	input wire logic [srzab_pkg::IN_UW-1:0]  s_tuser,
	input wire logic                         m_tvalid,
	input wire logic                         m_tready,
	input wire logic [srzab_pkg::OUT_DW-1:0] m_tdata,
	input wire logic [srzab_pkg::OUT_UW-1:0] m_tuser
);
	import srzab_pkg::*;

	localparam logic [3:0] PIPE_DEPTH = 4'd6;

	logic [3:0] pend_q;
	logic       s_acc, m_acc;

	assign s_acc = s_tvalid && s_tready && (s_tuser[0] == OP_RENDER);
	assign m_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 4'd0;
		end else begin
			pend_q <= pend_q + 4'(s_acc) - 4'(m_acc);
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty output register");

	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 4'd0)
		else $error("result without an outstanding render transaction");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PIPE_DEPTH)
		else $error("more render transactions in flight than pipeline stages");

endmodule

bind sprite_rotozoom_alpha_blend srzab_checker u_srzab_checker (.*);
`default_nettype wire

### test/tb_sprite_rotozoom_alpha_blend.sv
// Self-checking testbench for the sprite rotate, zoom and alpha blend block.
`default_nettype none
module tb_sprite_rotozoom_alpha_blend;
	import srzab_pkg::*;

	typedef struct packed {
		logic [31:0] pix;
		logic        changed;
	} pixel_result_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [IN_DW-1:0]    s_tdata;
	logic [IN_UW-1:0]    s_tuser;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_DW-1:0]   m_tdata;
	logic [OUT_UW-1:0]   m_tuser;
	logic                cfg_we;
	logic [CFG_IW-1:0]   cfg_idx;
	logic [CFG_DW-1:0]   cfg_data;

	sprite_rotozoom_alpha_blend uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	longint rot_sin = 0;
	longint rot_cos = 4096;
	longint inv_sx = 4096;
	longint inv_sy = 4096;
	longint win_left = 0;
	longint win_top = 0;
	longint win_right = 256;
	longint win_bottom = 256;

	logic [31:0]   texel_mem [TEX_WORDS];
	bit            texel_loaded [TEX_WORDS];
	pixel_result_t expected_pixels [$];

	int idle_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int n_loads = 0;
	int n_renders = 0;
	int n_changed = 0;
	int n_settings = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic bit locate_texel(input logic signed [15:0] x, input logic signed [15:0] y,
			output logic [15:0] addr);
		longint r, q, nx, ny, col, row;
		addr = '0;
		if (inv_sx == 0 || inv_sy == 0)
			return 1'b0;
		r = (longint'(x) * rot_cos - longint'(y) * rot_sin) >>> Q12;
		nx = ((r * inv_sx) >>> Q12) - (inv_sx < 0 ? 1 : 0);
		if (nx < win_left || nx >= win_right)
			return 1'b0;
		q = (longint'(x) * rot_sin + longint'(y) * rot_cos) >>> Q12;
		ny = ((q * inv_sy) >>> Q12) - (inv_sy < 0 ? 1 : 0);
		if (ny < win_top || ny >= win_bottom)
			return 1'b0;
		col = nx - win_left;
		row = ny - win_top;
		if (col >= TEX_WIDTH || row >= TEX_HEIGHT)
			return 1'b0;
		addr = 16'(row * TEX_WIDTH + col);
		return 1'b1;
	endfunction

	function automatic logic [31:0] blend_argb(input logic [31:0] s, input logic [31:0] d,
			input int sa);
		logic [31:0] res;
		int k;
		res = 32'hff000000;
		for (k = 0; k < 24; k += 8)
			res[k +: 8] = 8'((int'(s[k +: 8]) * (sa + 1) + int'(d[k +: 8]) * (256 - sa)) >> 8);
		return res;
	endfunction

	function automatic pixel_result_t shade_pixel(input in_t it);
		pixel_result_t res;
		logic [15:0] addr;
		logic [31:0] tx;
		int sa, da;
		res.pix = it.dst_pixel;
		res.changed = 1'b0;
		if (!locate_texel(it.dst_x, it.dst_y, addr))
			return res;
		tx = texel_mem[addr];
		da = it.dst_no_alpha ? 255 : int'(it.dst_pixel[31:24]);
		sa = it.src_no_alpha ? 255 : int'(tx[31:24]);
		if (sa == 0)
			return res;
		res.pix = (da == 0 || sa == 255) ? tx : blend_argb(tx, it.dst_pixel, sa);
		res.changed = 1'b1;
		return res;
	endfunction

	function automatic logic [31:0] random_argb();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(3))
			0: v[31:24] = ALPHA_CLEAR;
			1: v[31:24] = ALPHA_OPAQUE;
			default: ;
		endcase
		return v;
	endfunction

	// A render with coordinates mostly near the origin, where the source window usually lies.
	function automatic in_t random_item();
		in_t it;
		it.op = OP_RENDER;
		it.tex_col = 8'($urandom);
		it.tex_row = 8'($urandom);
		it.texel = random_argb();
		if ($urandom_range(9) == 0) begin
			it.dst_x = 16'($urandom);
			it.dst_y = 16'($urandom);
		end else begin
			it.dst_x = 16'(int'($urandom_range(800)) - 400);
			it.dst_y = 16'(int'($urandom_range(800)) - 400);
		end
		it.dst_pixel = random_argb();
		it.dst_no_alpha = ($urandom_range(3) == 0);
		it.src_no_alpha = ($urandom_range(3) == 0);
		return it;
	endfunction

	task automatic send_item(input in_t it);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {it.dst_pixel, it.dst_y, it.dst_x, it.texel, it.tex_row, it.tex_col};
		s_tuser <= {it.src_no_alpha, it.dst_no_alpha, it.op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (it.op == OP_LOAD) begin
			texel_mem[{it.tex_row, it.tex_col}] = it.texel;
			texel_loaded[{it.tex_row, it.tex_col}] = 1'b1;
			n_loads++;
		end else begin
			expected_pixels.push_back(shade_pixel(it));
			n_renders++;
		end
	endtask

	// A render that would fetch a texel never written gets that texel loaded first.
	task automatic render_pixel(input in_t it);
		in_t fill;
		logic [15:0] addr;
		if (locate_texel(it.dst_x, it.dst_y, addr) && !texel_loaded[addr]) begin
			fill = random_item();
			fill.op = OP_LOAD;
			fill.tex_col = addr[7:0];
			fill.tex_row = addr[15:8];
			send_item(fill);
		end
		send_item(it);
	endtask

	task automatic random_items(input int n);
		in_t it;
		repeat (n) begin
			it = random_item();
			if ($urandom_range(7) == 0) begin
				it.op = OP_LOAD;
				send_item(it);
			end else begin
				render_pixel(it);
			end
		end
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input longint value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= CFG_DW'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SIN:     rot_sin = longint'($signed(value[13:0]));
			REG_COS:     rot_cos = longint'($signed(value[13:0]));
			REG_SCALE_X: inv_sx = longint'($signed(value[21:0]));
			REG_SCALE_Y: inv_sy = longint'($signed(value[21:0]));
			REG_LEFT:    win_left = longint'($signed(value[15:0]));
			REG_TOP:     win_top = longint'($signed(value[15:0]));
			REG_RIGHT:   win_right = longint'($signed(value[15:0]));
			REG_BOTTOM:  win_bottom = longint'($signed(value[15:0]));
			default: ;
		endcase
	endtask

	task automatic program_regs(input longint s, input longint c, input longint sx,
			input longint sy, input longint l, input longint t, input longint r, input longint b);
		drain();
		write_reg(REG_SIN, s);
		write_reg(REG_COS, c);
		write_reg(REG_SCALE_X, sx);
		write_reg(REG_SCALE_Y, sy);
		write_reg(REG_LEFT, l);
		write_reg(REG_TOP, t);
		write_reg(REG_RIGHT, r);
		write_reg(REG_BOTTOM, b);
		n_settings++;
	endtask

	task automatic program_random();
		real rad;
		int s, c, sx, sy, l, t;
		rad = real'($urandom_range(359)) * 3.14159265358979 / 180.0;
		s = $rtoi($sin(rad) * 4096.0);
		c = $rtoi($cos(rad) * 4096.0);
		if ($urandom_range(3) == 0) begin
			s = int'($urandom_range(8192)) - 4096;
			c = int'($urandom_range(8192)) - 4096;
		end
		sx = int'($urandom_range(2048, 8192));
		sy = int'($urandom_range(2048, 8192));
		if ($urandom_range(1))
			sx = -sx;
		if ($urandom_range(1))
			sy = -sy;
		l = -int'($urandom_range(256));
		t = -int'($urandom_range(256));
		program_regs(s, c, sx, sy, l, t, l + int'($urandom_range(16, 320)),
			t + int'($urandom_range(16, 320)));
	endtask

	function automatic in_t make_item(input op_t op, input int xc, input int yr,
			input logic [31:0] argb, input logic dna, input logic sna);
		in_t it;
		it = random_item();
		it.op = op;
		it.tex_col = 8'(xc);
		it.tex_row = 8'(yr);
		it.texel = argb;
		it.dst_x = 16'(xc);
		it.dst_y = 16'(yr);
		it.dst_pixel = argb;
		it.dst_no_alpha = dna;
		it.src_no_alpha = sna;
		return it;
	endfunction

	task automatic test_directed();
		idle_pct = 0;
		stall_pct = 0;
		send_item(make_item(OP_LOAD, 0, 0, 32'h00123456, 1'b0, 1'b0));
		send_item(make_item(OP_LOAD, 255, 255, 32'hffa5c3e1, 1'b0, 1'b0));
		send_item(make_item(OP_LOAD, 1, 0, 32'h80ff0080, 1'b0, 1'b0));
		send_item(make_item(OP_LOAD, 2, 0, 32'h01ffffff, 1'b0, 1'b0));
		send_item(make_item(OP_LOAD, 3, 0, 32'hfe10e0f0, 1'b0, 1'b0));
		render_pixel(make_item(OP_RENDER, 0, 0, 32'h80404040, 1'b0, 1'b0));
		render_pixel(make_item(OP_RENDER, 0, 0, 32'h80404040, 1'b0, 1'b1));
		render_pixel(make_item(OP_RENDER, 255, 255, 32'h7f000000, 1'b0, 1'b0));
		render_pixel(make_item(OP_RENDER, 1, 0, 32'h00ffffff, 1'b0, 1'b0));
		render_pixel(make_item(OP_RENDER, 1, 0, 32'h40102030, 1'b0, 1'b0));
		render_pixel(make_item(OP_RENDER, 1, 0, 32'h00204060, 1'b1, 1'b0));
		render_pixel(make_item(OP_RENDER, 2, 0, 32'hc0000000, 1'b0, 1'b0));
		render_pixel(make_item(OP_RENDER, 3, 0, 32'hffffffff, 1'b0, 1'b0));
		render_pixel(make_item(OP_RENDER, 256, 0, 32'hff00ff00, 1'b0, 1'b1));
		render_pixel(make_item(OP_RENDER, -1, 0, 32'hff00ff00, 1'b0, 1'b1));
		render_pixel(make_item(OP_RENDER, 0, 256, 32'hff00ff00, 1'b0, 1'b1));
		render_pixel(make_item(OP_RENDER, 0, -1, 32'hff00ff00, 1'b0, 1'b1));
		render_pixel(make_item(OP_RENDER, -32768, 32767, 32'h12345678, 1'b1, 1'b1));
		render_pixel(make_item(OP_RENDER, 32767, -32768, 32'h87654321, 1'b1, 1'b1));
	endtask

	task automatic test_register_extremes();
		idle_pct = 28;
		stall_pct = 28;
		program_regs(4096, 0, 4096, 4096, 0, 0, 256, 256);
		random_items(25);
		program_regs(-2896, 2896, -8192, 2048, -128, -128, 128, 128);
		random_items(25);
		program_regs(-4096, -4096, -1048576, 1048576, -32768, -32768, 32767, 32767);
		random_items(25);
		program_regs(0, 4096, 0, 4096, 0, 0, 256, 256);
		random_items(25);
		program_regs(1000, 3000, 4096, 0, 0, 0, 256, 256);
		random_items(25);
		program_regs(8191, -8192, 2097151, -2097152, 32767, 32767, -32768, -32768);
		random_items(25);
		program_regs(0, 4096, 4096, 4096, -200, -300, 400, 300);
		random_items(25);
	endtask

	task automatic test_stream_phases();
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 62; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 62; end
				default: begin idle_pct = 28; stall_pct = 28; end
			endcase
			program_random();
			random_items(90);
			drain();
			random_items(90);
		end
	endtask

	always @(posedge clk) begin
		pixel_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_pixels.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, actual out_pixel=%h changed=%b",
					$time, m_tdata, m_tuser[0]);
			end else begin
				want = expected_pixels.pop_front();
				if (m_tdata !== want.pix) begin
					errors++;
					$display("%0t: out_pixel expected %h actual %h", $time, want.pix, m_tdata);
				end
				if (m_tuser[0] !== want.changed) begin
					errors++;
					$display("%0t: changed expected %b actual %b", $time, want.changed, m_tuser[0]);
				end
				if (want.changed)
					n_changed++;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_register_extremes();
		test_stream_phases();
		drain();
		$display("Ran %0d texel loads and %0d pixel renders over %0d register settings.",
			n_loads, n_renders, n_settings);
		$display("%0d pixels were copied or blended, %0d were kept.",
			n_changed, n_renders - n_changed);
		if (errors == 0)
			$display("sprite_rotozoom_alpha_blend: match");
		else
			$display("sprite_rotozoom_alpha_blend: mismatch");
		$finish;
	end

	initial begin
		#(12 * 400000);
		$display("Timed out with %0d results outstanding.", expected_pixels.size());
		$display("sprite_rotozoom_alpha_blend: mismatch");
		$finish;
	end

endmodule
`default_nettype wire
